FILE: sv/cfmp_pkg.sv
// ----------------------------------------------------------------------------
// cfmp_pkg
// Types and constants for the crontab time field mask parser.
// ----------------------------------------------------------------------------
package cfmp_pkg;

  // Width of the value mask; bits at or above it are never set.
  localparam int MASK_WIDTH = 32;

  // Configuration register geometry.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int LIMIT_W    = 5;

  // Number accumulators saturate at ACC_LIMIT.
  localparam int NUM_W     = 10;
  localparam int ACC_LIMIT = 1023;

  // Products used by the accumulate and divide-by-ten logic.
  localparam int ACC_SUM_W = 14;
  localparam int DIV_PROD_W = 18;
  localparam int DIV_RECIP  = 205;
  localparam int DIV_SHIFT  = 11;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_VALUE    = 2'd0,
    REG_MAX_VALUE    = 2'd1,
    REG_MINUTES_MODE = 2'd2
  } cfg_reg_t;

  // Character codes.
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Result status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_NUMBER = 3'd1,
    PH_COMMA  = 3'd2,
    PH_RANGE  = 3'd3,
    PH_ALL    = 3'd4,
    PH_SKIP   = 3'd5
  } phase_t;

endpackage

FILE: sv/cron_field_mask_parser.sv
// ----------------------------------------------------------------------------
// cron_field_mask_parser
// Parses one crontab time field, one character per transfer, into a value mask.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                               Direction  Moves
//  -------  ----------------------------------  ---------  -----------------------
//  in       in_valid/in_ready, in_char_code     input      one field character
//  out      out_valid/out_ready, out_status,    output     one result per field
//           out_value_mask
//  cfg      cfg_we, cfg_index, cfg_wdata        input      limit and mode writes
//
// Every character is consumed in the cycle of its transfer: the parse state,
// the number accumulators and the mask are updated by one level of logic, and
// a finished field loads the output register. Sustained rate is one character
// per cycle; the input stalls only while a result sits unclaimed in the output
// register and out_ready is low. Reset (rst_n low, synchronous) returns the
// parser to the start of a field, empties the output register and restores the
// default limits 0..31 with minutes mode off.
//
// A field is either '*' alone or a comma list of numbers and inclusive ranges
// a-b. In minutes mode each finished number is divided by ten before it is
// checked against the limits. Any error gives one result with the error status
// at once, after which characters are dropped up to the terminating zero byte.

module cron_field_mask_parser (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_char_code,

  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_status,
  output logic [cfmp_pkg::MASK_WIDTH-1:0]    out_value_mask,

  input  logic                               cfg_we,
  input  logic [cfmp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cfmp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int MW = cfmp_pkg::MASK_WIDTH;
  localparam int NW = cfmp_pkg::NUM_W;

  // Configuration registers.
  logic [cfmp_pkg::LIMIT_W-1:0] min_value_r;
  logic [cfmp_pkg::LIMIT_W-1:0] max_value_r;
  logic                         minutes_mode_r;

  // Parse state.
  cfmp_pkg::phase_t phase_r, phase_nxt;
  logic [NW-1:0]    range_start_r, range_start_nxt;
  logic [NW-1:0]    range_end_r, range_end_nxt;
  logic             end_seen_r, end_seen_nxt;
  logic [MW-1:0]    mask_acc_r, mask_acc_nxt;

  // Output register.
  logic             out_valid_r;
  logic             out_status_r, out_status_nxt;
  logic [MW-1:0]    out_mask_r, out_mask_nxt;
  logic             emit;

  logic in_fire;

  // Character decode.
  logic          is_digit, is_nul, is_star, is_comma, is_dash;
  logic [NW-1:0] digit_val;

  // Arithmetic on the accumulators.
  logic [NW-1:0] acc_start, acc_end;
  logic [NW-1:0] fin_start, fin_end;
  logic          start_ok, end_ok;

  // Mask generator.
  logic [NW-1:0] mark_lo, mark_hi;
  logic [MW-1:0] mark_mask;

  // Multiplies by ten, adds the new digit and saturates.
  function automatic logic [NW-1:0] accumulate(input logic [NW-1:0] acc,
                                               input logic [NW-1:0] dig);
    logic [cfmp_pkg::ACC_SUM_W-1:0] sum;
    sum = cfmp_pkg::ACC_SUM_W'(acc) * cfmp_pkg::ACC_SUM_W'(10)
        + cfmp_pkg::ACC_SUM_W'(dig);
    if (sum > cfmp_pkg::ACC_SUM_W'(cfmp_pkg::ACC_LIMIT)) begin
      return NW'(cfmp_pkg::ACC_LIMIT);
    end
    return sum[NW-1:0];
  endfunction

  // Divide by ten via reciprocal multiply; exact for all values below 1029.
  function automatic logic [NW-1:0] finish_number(input logic [NW-1:0] v,
                                                  input logic mm);
    logic [cfmp_pkg::DIV_PROD_W-1:0] prod;
    prod = cfmp_pkg::DIV_PROD_W'(v) * cfmp_pkg::DIV_PROD_W'(cfmp_pkg::DIV_RECIP);
    if (mm) begin
      return NW'(prod >> cfmp_pkg::DIV_SHIFT);
    end
    return v;
  endfunction

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_value_mask = out_mask_r;

  assign is_digit  = (in_char_code >= cfmp_pkg::CHAR_ZERO) &&
                     (in_char_code <= cfmp_pkg::CHAR_NINE);
  assign is_nul    = (in_char_code == cfmp_pkg::CHAR_NUL);
  assign is_star   = (in_char_code == cfmp_pkg::CHAR_STAR);
  assign is_comma  = (in_char_code == cfmp_pkg::CHAR_COMMA);
  assign is_dash   = (in_char_code == cfmp_pkg::CHAR_DASH);
  assign digit_val = NW'(in_char_code[3:0]);

  assign acc_start = accumulate(range_start_r, digit_val);
  assign acc_end   = accumulate(range_end_r, digit_val);
  assign fin_start = finish_number(range_start_r, minutes_mode_r);
  assign fin_end   = finish_number(range_end_r, minutes_mode_r);

  assign start_ok = (fin_start >= NW'(min_value_r)) && (fin_start <= NW'(max_value_r));
  assign end_ok   = (fin_end >= NW'(min_value_r)) && (fin_end <= NW'(max_value_r)) &&
                    (range_start_r <= fin_end);

  // One shared mask generator: '*' marks the full limit span, a single number
  // marks itself, and a range marks start through end.
  always_comb begin
    unique case (phase_r)
      cfmp_pkg::PH_NUMBER: begin
        mark_lo = fin_start;
        mark_hi = fin_start;
      end
      cfmp_pkg::PH_RANGE: begin
        mark_lo = range_start_r;
        mark_hi = fin_end;
      end
      default: begin
        mark_lo = NW'(min_value_r);
        mark_hi = NW'(max_value_r);
      end
    endcase
  end

  // Bit k stands for value min_value + k; values above 31 are never marked.
  always_comb begin
    logic [NW-1:0] v;
    for (int k = 0; k < MW; k++) begin
      v = NW'(min_value_r) + NW'(k);
      mark_mask[k] = (v >= mark_lo) && (v <= mark_hi) && (v <= NW'(31));
    end
  end

  // Next phase. Every move back to the start of a field also clears the
  // field state, whether the field finished well or failed on its terminator.
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      cfmp_pkg::PH_START: begin
        if (is_nul) begin
          phase_nxt = cfmp_pkg::PH_START;
        end else if (is_star) begin
          phase_nxt = cfmp_pkg::PH_ALL;
        end else if (is_digit) begin
          phase_nxt = cfmp_pkg::PH_NUMBER;
        end else begin
          phase_nxt = cfmp_pkg::PH_SKIP;
        end
      end
      cfmp_pkg::PH_ALL: begin
        phase_nxt = is_nul ? cfmp_pkg::PH_START : cfmp_pkg::PH_SKIP;
      end
      cfmp_pkg::PH_NUMBER: begin
        if (is_digit) begin
          phase_nxt = cfmp_pkg::PH_NUMBER;
        end else if (is_nul) begin
          phase_nxt = cfmp_pkg::PH_START;
        end else if (!(is_comma || is_dash) || !start_ok) begin
          phase_nxt = cfmp_pkg::PH_SKIP;
        end else if (is_dash) begin
          phase_nxt = cfmp_pkg::PH_RANGE;
        end else begin
          phase_nxt = cfmp_pkg::PH_COMMA;
        end
      end
      cfmp_pkg::PH_COMMA: begin
        if (is_digit) begin
          phase_nxt = cfmp_pkg::PH_NUMBER;
        end else if (is_nul) begin
          phase_nxt = cfmp_pkg::PH_START;
        end else begin
          phase_nxt = cfmp_pkg::PH_SKIP;
        end
      end
      cfmp_pkg::PH_RANGE: begin
        if (is_digit) begin
          phase_nxt = cfmp_pkg::PH_RANGE;
        end else if (is_nul) begin
          phase_nxt = cfmp_pkg::PH_START;
        end else if (!is_comma || !end_seen_r || !end_ok) begin
          phase_nxt = cfmp_pkg::PH_SKIP;
        end else begin
          phase_nxt = cfmp_pkg::PH_COMMA;
        end
      end
      cfmp_pkg::PH_SKIP: begin
        phase_nxt = is_nul ? cfmp_pkg::PH_START : cfmp_pkg::PH_SKIP;
      end
      default: begin
        phase_nxt = cfmp_pkg::PH_START;
      end
    endcase
  end

  // Field data and the result.
  always_comb begin
    logic fail;
    logic done;
    fail            = 1'b0;
    done            = 1'b0;
    range_start_nxt = range_start_r;
    range_end_nxt   = range_end_r;
    end_seen_nxt    = end_seen_r;
    mask_acc_nxt    = mask_acc_r;

    unique case (phase_r)
      cfmp_pkg::PH_START: begin
        if (is_nul) begin
          done = 1'b1;
        end else if (is_star) begin
          mask_acc_nxt = mask_acc_r | mark_mask;
        end else if (is_digit) begin
          range_start_nxt = digit_val;
        end else begin
          fail = 1'b1;
        end
      end
      cfmp_pkg::PH_ALL: begin
        done = is_nul;
        fail = !is_nul;
      end
      cfmp_pkg::PH_NUMBER: begin
        if (is_digit) begin
          range_start_nxt = acc_start;
        end else if (!(is_comma || is_dash || is_nul) || !start_ok) begin
          fail = 1'b1;
        end else if (is_dash) begin
          range_start_nxt = fin_start;
          range_end_nxt   = '0;
          end_seen_nxt    = 1'b0;
        end else begin
          range_start_nxt = fin_start;
          mask_acc_nxt    = mask_acc_r | mark_mask;
          done            = is_nul;
        end
      end
      cfmp_pkg::PH_COMMA: begin
        if (is_digit) begin
          range_start_nxt = digit_val;
        end else begin
          fail = 1'b1;
        end
      end
      cfmp_pkg::PH_RANGE: begin
        if (is_digit) begin
          range_end_nxt = end_seen_r ? acc_end : digit_val;
          end_seen_nxt  = 1'b1;
        end else if (!(is_comma || is_nul) || !end_seen_r || !end_ok) begin
          fail = 1'b1;
        end else begin
          range_end_nxt = fin_end;
          mask_acc_nxt  = mask_acc_r | mark_mask;
          end_seen_nxt  = 1'b0;
          done          = is_nul;
        end
      end
      default: begin
      end
    endcase

    // The result takes the mask including the terminating element, before the
    // field state is cleared below.
    emit           = fail || done;
    out_status_nxt = fail ? cfmp_pkg::STATUS_ERR : cfmp_pkg::STATUS_OK;
    out_mask_nxt   = fail ? '0 : mask_acc_nxt;

    if (phase_nxt == cfmp_pkg::PH_START) begin
      range_start_nxt = '0;
      range_end_nxt   = '0;
      end_seen_nxt    = 1'b0;
      mask_acc_nxt    = '0;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_value_r    <= '0;
      max_value_r    <= cfmp_pkg::LIMIT_W'(31);
      minutes_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cfmp_pkg::REG_MIN_VALUE:    min_value_r    <= cfg_wdata[cfmp_pkg::LIMIT_W-1:0];
        cfmp_pkg::REG_MAX_VALUE:    max_value_r    <= cfg_wdata[cfmp_pkg::LIMIT_W-1:0];
        cfmp_pkg::REG_MINUTES_MODE: minutes_mode_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Parse state advances on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= cfmp_pkg::PH_START;
      range_start_r <= '0;
      range_end_r   <= '0;
      end_seen_r    <= 1'b0;
      mask_acc_r    <= '0;
    end else if (in_fire) begin
      phase_r       <= phase_nxt;
      range_start_r <= range_start_nxt;
      range_end_r   <= range_end_nxt;
      end_seen_r    <= end_seen_nxt;
      mask_acc_r    <= mask_acc_nxt;
    end
  end

  // Output register: loads when a transfer finishes a field or reports an error,
  // frees when the result transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_status_r <= out_status_nxt;
      out_mask_r   <= out_mask_nxt;
    end
  end

endmodule

FILE: verif/cfmp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cfmp_checker
// Watches the crontab field parser's channels, predicts each result and compares.
// ----------------------------------------------------------------------------
// Keeps a private copy of the limit registers and of the field parse state. Every
// input transfer is run through the parser prediction; a predicted result is
// queued and compared field by field with the next output transfer.

module cfmp_checker
  import cfmp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            in_char_code,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_status,
  input  logic [MASK_WIDTH-1:0] out_value_mask,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    pending_results
);

  typedef struct {
    logic                  status;
    logic [MASK_WIDTH-1:0] mask;
  } field_result_t;

  field_result_t awaited_results[$];

  // Limit registers as the block should hold them.
  logic [LIMIT_W-1:0] lim_min;
  logic [LIMIT_W-1:0] lim_max;
  logic               div_mode;

  // Field parse state.
  phase_t                ph;
  int unsigned           first_num;
  int unsigned           last_num;
  logic                  last_seen;
  logic [MASK_WIDTH-1:0] sel_mask;

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
  end

  function automatic void clear_field();
    ph        = PH_START;
    first_num = 0;
    last_num  = 0;
    last_seen = 1'b0;
    sel_mask  = '0;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  function automatic int unsigned push_digit(input int unsigned acc, input logic [7:0] c);
    int unsigned v;
    v = acc * 10 + 32'(c - CHAR_ZERO);
    return (v > ACC_LIMIT) ? ACC_LIMIT : v;
  endfunction

  function automatic int unsigned scale_num(input int unsigned v);
    return div_mode ? v / 10 : v;
  endfunction

  function automatic bit within_limits(input int unsigned v);
    return v >= 32'(lim_min) && v <= 32'(lim_max);
  endfunction

  function automatic void mark_range(input int unsigned lo, input int unsigned hi);
    for (int unsigned v = lo; v <= hi && v <= 31; v++) begin
      if (v >= 32'(lim_min) && v - 32'(lim_min) < MASK_WIDTH) begin
        sel_mask[v - 32'(lim_min)] = 1'b1;
      end
    end
  endfunction

  // Advances the parse state by one character. Returns 1 when the character
  // finishes a field or reports an error, with the result in st and m.
  function automatic bit parse_char(input logic [7:0] c, output logic st,
                                    output logic [MASK_WIDTH-1:0] m);
    bit done;
    bit bad;
    done = 1'b0;
    bad  = 1'b0;
    case (ph)
      PH_START: begin
        if (c == CHAR_NUL) begin
          done = 1'b1;
        end else if (c == CHAR_STAR) begin
          if (lim_max >= lim_min) mark_range(32'(lim_min), 32'(lim_max));
          ph = PH_ALL;
        end else if (is_digit(c)) begin
          first_num = 32'(c - CHAR_ZERO);
          ph = PH_NUMBER;
        end else begin
          bad = 1'b1;
        end
      end
      PH_ALL: begin
        if (c == CHAR_NUL) done = 1'b1;
        else bad = 1'b1;
      end
      PH_NUMBER: begin
        if (is_digit(c)) begin
          first_num = push_digit(first_num, c);
        end else if (c == CHAR_COMMA || c == CHAR_DASH || c == CHAR_NUL) begin
          first_num = scale_num(first_num);
          if (!within_limits(first_num)) begin
            bad = 1'b1;
          end else if (c == CHAR_DASH) begin
            last_num  = 0;
            last_seen = 1'b0;
            ph = PH_RANGE;
          end else begin
            mark_range(first_num, first_num);
            if (c == CHAR_NUL) done = 1'b1;
            else ph = PH_COMMA;
          end
        end else begin
          bad = 1'b1;
        end
      end
      PH_COMMA: begin
        if (is_digit(c)) begin
          first_num = 32'(c - CHAR_ZERO);
          ph = PH_NUMBER;
        end else begin
          bad = 1'b1;
        end
      end
      PH_RANGE: begin
        if (is_digit(c)) begin
          last_num  = last_seen ? push_digit(last_num, c) : 32'(c - CHAR_ZERO);
          last_seen = 1'b1;
        end else if (c == CHAR_COMMA || c == CHAR_NUL) begin
          if (!last_seen) begin
            bad = 1'b1;
          end else begin
            last_num = scale_num(last_num);
            if (!within_limits(last_num) || first_num > last_num) begin
              bad = 1'b1;
            end else begin
              mark_range(first_num, last_num);
              if (c == CHAR_NUL) begin
                done = 1'b1;
              end else begin
                last_seen = 1'b0;
                ph = PH_COMMA;
              end
            end
          end
        end else begin
          bad = 1'b1;
        end
      end
      default: begin
        if (c == CHAR_NUL) clear_field();
      end
    endcase
    st = STATUS_OK;
    m  = '0;
    if (bad) begin
      st = STATUS_ERR;
      if (c == CHAR_NUL) clear_field();
      else ph = PH_SKIP;
      return 1'b1;
    end
    if (done) begin
      m = sel_mask;
      clear_field();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic flag_error(input string what);
    if (mismatch_count < 10) $display("%0t: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    field_result_t         want;
    logic                  new_st;
    logic [MASK_WIDTH-1:0] new_mask;
    if (!rst_n) begin
      lim_min  = '0;
      lim_max  = 5'd31;
      div_mode = 1'b0;
      clear_field();
      awaited_results.delete();
    end else begin
      // Compare before predicting, so a result is never matched against an
      // expectation raised at the same edge.
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          flag_error($sformatf("result with none expected: status %0d mask %08h",
                               out_status, out_value_mask));
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status || out_value_mask !== want.mask) begin
            flag_error($sformatf("expected status %0d mask %08h, got status %0d mask %08h",
                                 want.status, want.mask, out_status, out_value_mask));
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_VALUE:    lim_min  = cfg_wdata[LIMIT_W-1:0];
          REG_MAX_VALUE:    lim_max  = cfg_wdata[LIMIT_W-1:0];
          REG_MINUTES_MODE: div_mode = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (parse_char(in_char_code, new_st, new_mask)) begin
          awaited_results.push_back('{new_st, new_mask});
        end
      end
    end
    pending_results = awaited_results.size();
  end

endmodule

FILE: verif/cron_field_mask_parser_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cron_field_mask_parser_test
// Stimulus and verdict for the crontab time field mask parser.
// ----------------------------------------------------------------------------
// A short directed run covers the empty field, '*', a range followed by a comma,
// accumulator saturation, an empty range end, a reversed range, a trailing comma
// and a high character code. Then eight phases, each under its own limit and
// mode settings, send random fields: most are well formed, the rest are broken
// or plain noise. The checker beside the block predicts and compares; this
// module only drives the channels and reports the outcome.

module cron_field_mask_parser_test;
  import cfmp_pkg::*;

  // Far above the slowest legal run: about 950 characters, each with a sender
  // gap and a receiver stall, plus the drains between phases.
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_CHARS = 115;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_char_code = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_status;
  logic [MASK_WIDTH-1:0] out_value_mask;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_MIN_VALUE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatch_count;
  int pending_results;
  int cycle_count = 0;
  int chars_sent = 0;
  int stall_left = 0;

  // When low, neither side idles.
  bit gaps_on = 1'b1;

  // Limits in force, used only to steer random numbers into range.
  int shape_min = 0;
  int shape_max = 31;
  bit shape_minutes = 1'b0;

  logic [7:0] field_chars[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  cron_field_mask_parser i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_value_mask (out_value_mask),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  cfmp_checker i_result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_code    (in_char_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_value_mask  (out_value_mask),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: out_ready drops in bursts while gaps are on.
  // Exactly one assignment to out_ready per edge.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offers one character and returns at the edge of its transfer. Valid stays
  // high from one character to the next unless a gap is inserted, so it is
  // never lowered and raised within the same time step.
  task automatic send_char(input logic [7:0] c);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(CHAR_NUL);
  endtask

  // Stops the sender and waits until every predicted result has been taken.
  // The checker's counters are read at the falling edge, away from its updates.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
    // A character that causes no result is consumed in its own cycle, so a
    // few more edges leave the parser idle.
    repeat (3) @(posedge clk);
  endtask

  // Writes all three registers back to back; write enable stays high across them.
  task automatic set_limits(input int lo, input int hi, input bit minutes);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MIN_VALUE;
    cfg_wdata <= CFG_DATA_W'(lo);
    @(posedge clk);
    cfg_index <= REG_MAX_VALUE;
    cfg_wdata <= CFG_DATA_W'(hi);
    @(posedge clk);
    cfg_index <= REG_MINUTES_MODE;
    cfg_wdata <= CFG_DATA_W'(minutes);
    @(posedge clk);
    cfg_we <= 1'b0;
    shape_min     = lo;
    shape_max     = hi;
    shape_minutes = minutes;
  endtask

  // A number as written in the field. Mostly it lands inside the limits after
  // the minutes scaling; now and then it is anything up to well past saturation.
  function automatic int pick_number();
    int v;
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 99999);
    if (shape_max >= shape_min) v = $urandom_range(shape_min, shape_max);
    else v = $urandom_range(0, 31);
    return shape_minutes ? v * 10 + $urandom_range(0, 9) : v;
  endfunction

  function automatic void push_number(input int n);
    string s;
    s = $sformatf("%0d", n);
    if ($urandom_range(0, 7) == 0) field_chars.push_back(CHAR_ZERO);
    for (int i = 0; i < s.len(); i++) field_chars.push_back(s[i]);
  endfunction

  // Builds one field, terminator included, in field_chars.
  function automatic void build_field();
    int kind;
    int a;
    int b;
    int t;
    int cut;
    field_chars.delete();
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      field_chars.push_back(CHAR_STAR);
    end else if (kind == 1) begin
      // Empty field: just the terminator.
    end else if (kind <= 3) begin
      // Noise: any nonzero codes, high ones included.
      repeat ($urandom_range(1, 6)) field_chars.push_back(8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        if (field_chars.size() != 0) field_chars.push_back(CHAR_COMMA);
        a = pick_number();
        cut = field_chars.size();
        push_number(a);
        if ($urandom_range(0, 1) == 1) begin
          b = pick_number();
          // Keep most ranges ascending; the rest test start above end.
          if (b < a && $urandom_range(0, 3) != 0) begin
            t = a;
            a = b;
            b = t;
            // Rewrite only this element's start; earlier elements stay.
            while (field_chars.size() > cut) void'(field_chars.pop_back());
            push_number(a);
          end
          field_chars.push_back(CHAR_DASH);
          push_number(b);
        end
      end
      // Break a few well-formed fields in the ways that matter.
      if (kind <= 6) begin
        case ($urandom_range(0, 2))
          0: field_chars[$urandom_range(0, field_chars.size() - 1)] =
               8'($urandom_range(0, 255));
          1: field_chars.push_back(CHAR_COMMA);
          default: field_chars.push_back(CHAR_DASH);
        endcase
      end
    end
    field_chars.push_back(CHAR_NUL);
  endfunction

  initial begin
    int lo;
    int hi;
    bit md;
    int phase_start;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed fields under the reset limits 0..31, minutes mode off.
    send_text("");
    send_text("*");
    send_text("2-9,4");
    send_text("99999");
    send_text("5-");
    send_text("3-1");
    send_text("7,");
    send_char(8'hB5);
    send_char("1");
    send_char(CHAR_NUL);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin lo = 0;  hi = 31; md = 1'b1; end
        1: begin lo = 30; hi = 31; md = 1'b0; end
        2: begin lo = 20; hi = 5;  md = 1'b0; end // crossed limits select nothing
        3: begin lo = 0;  hi = 1;  md = 1'b1; end
        7: begin lo = 0;  hi = 31; md = 1'b0; end
        default: begin
          lo = $urandom_range(0, 30);
          hi = $urandom_range(lo + 1, 31);
          md = $urandom_range(0, 1);
        end
      endcase
      // Registers change only once every result of the last phase is in.
      drain();
      set_limits(lo, hi, md);
      // Phase four runs without idling, and so does the final phase.
      gaps_on = (p != 4 && p != 7);
      phase_start = chars_sent;
      while (chars_sent - phase_start < PHASE_CHARS) begin
        build_field();
        foreach (field_chars[i]) send_char(field_chars[i]);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
